[design/svpwm_pkg.sv]
// shared types and constants for the svpwm compare generator
package svpwm_pkg;

  localparam logic [14:0] SQRT3_HALF = 15'd28378;
  localparam logic signed [17:0] PHASE_MAX = 18'sd32767;
  localparam logic [14:0] DUTY_FULL = 15'h7fff;

  localparam logic [14:0] DUTY_MIN_RST = 15'd0;
  localparam logic [14:0] DUTY_MAX_RST = 15'h7fff;
  localparam logic [15:0] TIMER_MAX_RST = 16'hffff;

  localparam logic [1:0] CFG_DUTY_MIN = 2'd0;
  localparam logic [1:0] CFG_DUTY_MAX = 2'd1;
  localparam logic [1:0] CFG_TIMER_MAX = 2'd2;

  typedef struct packed {
    logic signed [15:0] va;
    logic signed [16:0] vb;
    logic signed [16:0] vc;
  } phase_t;

  typedef struct packed {
    logic [14:0] duty_min;
    logic [14:0] duty_max;
    logic [15:0] timer_max;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/svpwm_front.sv]
// front end: input register, beta multiply and inverse clarke
module svpwm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // alpha[15:0], beta[31:16]
  input  svpwm_pkg::q_status_t  q_status,
  output logic                  push,
  output svpwm_pkg::phase_t     push_data
);

  logic               valid;
  logic signed [15:0] alpha;
  logic signed [31:0] prod;
  logic signed [31:0] prod_next;
  logic signed [15:0] beta_in;
  logic signed [31:0] alpha_sh;
  logic signed [31:0] sum_b;
  logic signed [31:0] sum_c;

  assign beta_in   = $signed(s_tdata[31:16]);
  assign prod_next = beta_in * $signed({1'b0, svpwm_pkg::SQRT3_HALF});

  assign s_tready = !valid || !q_status.full;
  assign push     = valid && !q_status.full;

  // -16384*a +/- 28378*b, then floor by 2^15
  assign alpha_sh = {{2{alpha[15]}}, alpha, 14'd0};
  assign sum_b    = prod - alpha_sh;
  assign sum_c    = 32'sd0 - prod - alpha_sh;

  assign push_data.va = alpha;
  assign push_data.vb = sum_b[31:15];
  assign push_data.vc = sum_c[31:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      alpha <= $signed(s_tdata[15:0]);
      prod  <= prod_next;
    end
  end

endmodule

[design/svpwm_queue.sv]
// small fifo between front and back end
module svpwm_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  svpwm_pkg::phase_t     push_data,
  input  logic                  pop,
  output svpwm_pkg::phase_t     head,
  output svpwm_pkg::q_status_t  status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  svpwm_pkg::phase_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/svpwm_back.sv]
// back end: zero-sequence injection, saturation and scaling to timer counts
module svpwm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  svpwm_pkg::q_status_t  q_status,
  input  svpwm_pkg::phase_t     head,
  input  svpwm_pkg::cfg_t       cfg,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata    // cnt_a[15:0], cnt_b[31:16], cnt_c[47:32]
);

  logic               v1;
  logic               v2;
  logic               v3;
  logic               en1;
  logic               en2;
  logic               en3;
  logic signed [16:0] ph [3];
  logic signed [16:0] hi;
  logic signed [16:0] lo;
  logic signed [17:0] hl_sum;
  logic signed [16:0] off;
  logic signed [17:0] diff_next [3];
  logic signed [17:0] diff [3];
  logic [14:0]        duty_next [3];
  logic [14:0]        duty [3];
  logic [30:0]        scaled [3];
  logic [15:0]        cmp [3];

  function automatic logic [14:0] saturate(input logic signed [17:0] d,
                                           input logic [14:0] dmin,
                                           input logic [14:0] dmax);
    logic [14:0] c;
    if (d > svpwm_pkg::PHASE_MAX) begin
      c = svpwm_pkg::DUTY_FULL;
    end else if (d < $signed({3'b000, dmin})) begin
      c = dmin;
    end else begin
      c = d[14:0];
    end
    if (c > dmax) begin
      c = dmax;
    end
    return c;
  endfunction

  assign en3 = !v3 || m_tready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = !q_status.empty && en1;

  assign m_tvalid = v3;
  assign m_tdata  = {cmp[2], cmp[1], cmp[0]};

  assign ph[0] = {head.va[15], head.va};
  assign ph[1] = head.vb;
  assign ph[2] = head.vc;

  always_comb begin
    hi = ph[0];
    lo = ph[0];
    for (int i = 1; i < 3; i++) begin
      if (ph[i] > hi) hi = ph[i];
      if (ph[i] < lo) lo = ph[i];
    end
    hl_sum = {hi[16], hi} + {lo[16], lo};
    off    = hl_sum[17:1];
    for (int i = 0; i < 3; i++) begin
      diff_next[i] = {ph[i][16], ph[i]} - {off[16], off};
      duty_next[i] = saturate(diff[i], cfg.duty_min, cfg.duty_max);
      scaled[i]    = duty[i] * cfg.timer_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= !q_status.empty;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (pop) diff[i] <= diff_next[i];
      if (en2 && v1) duty[i] <= duty_next[i];
      if (en3 && v2) cmp[i] <= scaled[i][30:15];
    end
  end

endmodule

[design/svpwm_compare_generator.sv]
// top level of the svpwm compare generator
//
// input stream s_*: one alpha/beta vector per transaction, signed q15 each.
// output stream m_*: three unsigned 16-bit timer compare counts per
// transaction, one result for every input vector, in order.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 duty_min, 1 duty_max, 2 timer_max); other indexes are dropped.
// front end registers the input and the beta multiply and forms the three
// phase voltages; a QUEUE_DEPTH entry fifo decouples it from the back end,
// which injects the min/max offset, saturates and scales in three stages.
// a result passes the input register, a fifo entry and the diff, duty and compare registers, in that order.
// throughput: one vector per cycle unless m_tready stalls the output; each stage holds one multiply per phase at most.
// a stalled m_tready holds the output register and back end; the front end
// keeps taking vectors until the fifo fills, then drops s_tready.
// reset (rst, synchronous) empties the pipeline and fifo and restores
// duty_min 0, duty_max 32767, timer_max 65535.
module svpwm_compare_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // alpha[15:0], beta[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // cnt_a[15:0], cnt_b[31:16], cnt_c[47:32]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  svpwm_pkg::cfg_t      cfg;
  svpwm_pkg::q_status_t q_status;
  svpwm_pkg::phase_t    push_data;
  svpwm_pkg::phase_t    head;
  logic                 push;
  logic                 pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_min  <= svpwm_pkg::DUTY_MIN_RST;
      cfg.duty_max  <= svpwm_pkg::DUTY_MAX_RST;
      cfg.timer_max <= svpwm_pkg::TIMER_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svpwm_pkg::CFG_DUTY_MIN:  cfg.duty_min  <= cfg_data[14:0];
        svpwm_pkg::CFG_DUTY_MAX:  cfg.duty_max  <= cfg_data[14:0];
        svpwm_pkg::CFG_TIMER_MAX: cfg.timer_max <= cfg_data;
        default: ;
      endcase
    end
  end

  svpwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  svpwm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  svpwm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .cfg      (cfg),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTH
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_rst_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

[sim/tb_svpwm_compare_generator.sv]
// self-checking testbench for the svpwm compare generator
module tb_svpwm_compare_generator;

  localparam int CLK_PERIOD = 12;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [47:0] HALF_Q15 = 48'sd16384;
  localparam logic signed [47:0] SQRT3_Q15 = 48'sd28378;
  localparam logic signed [47:0] Q15_HI = 48'sd32767;
  localparam logic signed [47:0] Q15_LO = -48'sd32768;

  typedef struct {
    logic [31:0] vec;
    logic [47:0] cmp;
  } compare_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // alpha[15:0], beta[31:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // cnt_a[15:0], cnt_b[31:16], cnt_c[47:32]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [14:0] duty_min_q = svpwm_pkg::DUTY_MIN_RST;
  logic [14:0] duty_max_q = svpwm_pkg::DUTY_MAX_RST;
  logic [15:0] timer_max_q = svpwm_pkg::TIMER_MAX_RST;

  compare_entry_t pending_compares[$];
  int bad_count = 0;
  int result_count = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int stall_request = 0;

  svpwm_compare_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [47:0] compute_compares(input logic [31:0] vec);
    logic signed [47:0] a, b, vb, vc, hi, lo, off, ph, dmin, dmax, tmax;
    logic signed [47:0] phase[3];
    logic [47:0] prod;
    logic [47:0] res;
    a = 48'($signed(vec[15:0]));
    b = 48'($signed(vec[31:16]));
    dmin = 48'(duty_min_q);
    dmax = 48'(duty_max_q);
    tmax = 48'(timer_max_q);
    vb = (-HALF_Q15 * a + SQRT3_Q15 * b) >>> 15;
    vc = (-HALF_Q15 * a - SQRT3_Q15 * b) >>> 15;
    hi = a;
    lo = a;
    if (vb > hi) hi = vb;
    if (vc > hi) hi = vc;
    if (vb < lo) lo = vb;
    if (vc < lo) lo = vc;
    off = (hi + lo) >>> 1;
    phase[0] = a - off;
    phase[1] = vb - off;
    phase[2] = vc - off;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      ph = phase[i];
      if (ph > Q15_HI) ph = Q15_HI;
      if (ph < Q15_LO) ph = Q15_LO;
      if (ph < dmin) ph = dmin;
      if (ph > dmax) ph = dmax;
      prod = ph * tmax;
      res[16*i +: 16] = prod[30:15];
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] corner_vector(input int idx);
    case (idx)
      0:  return {16'sd0, 16'sd0};
      1:  return {16'sd0, 16'sd32767};
      2:  return {16'sd0, 16'sh8000};
      3:  return {16'sd32767, 16'sd0};
      4:  return {16'sh8000, 16'sd0};
      5:  return {16'sd32767, 16'sd32767};
      6:  return {16'sh8000, 16'sh8000};
      7:  return {16'sh8000, 16'sd32767};
      8:  return {16'sd32767, 16'sh8000};
      9:  return {-16'sd1, 16'sd1};
      10: return {16'sd28378, -16'sd16384};
      default: return {-16'sd18919, 16'sh8000};
    endcase
  endfunction

  // output check first, then record the input transaction of the same edge
  always @(posedge clk) begin
    compare_entry_t e;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (pending_compares.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("result %0d with nothing pending: got %h", result_count, m_tdata);
      end else begin
        e = pending_compares.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[16*i +: 16] !== e.cmp[16*i +: 16]) begin
            bad_count++;
            if (bad_count <= 10)
              $display("result %0d phase %0d alpha %0d beta %0d: expected %0d got %0d",
                       result_count, i, $signed(e.vec[15:0]), $signed(e.vec[31:16]),
                       e.cmp[16*i +: 16], m_tdata[16*i +: 16]);
          end
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      e.vec = s_tdata;
      e.cmp = compute_compares(s_tdata);
      pending_compares.push_back(e);
    end
  end

  // receiver: random ready with an on-demand long hold-off
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (stall_request > 0) begin
        hold = stall_request;
        stall_request = 0;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
        m_tready <= (hold == 0);
        if (hold > 0) hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_vector(input logic [31:0] vec);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= vec;
    do @(posedge clk); while (!s_tready);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_compares.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      svpwm_pkg::CFG_DUTY_MIN:  duty_min_q = data[14:0];
      svpwm_pkg::CFG_DUTY_MAX:  duty_max_q = data[14:0];
      svpwm_pkg::CFG_TIMER_MAX: timer_max_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_corners(input int count);
    for (int i = 0; i < count; i++) send_vector(corner_vector(i));
  endtask

  task automatic test_reset_defaults();
    send_corners(12);
  endtask

  task automatic test_narrow_window();
    settle();
    write_reg(svpwm_pkg::CFG_DUTY_MIN, 16'd8000);
    write_reg(svpwm_pkg::CFG_DUTY_MAX, 16'd20000);
    write_reg(svpwm_pkg::CFG_TIMER_MAX, 16'd1000);
    send_corners(4);
  endtask

  // lower bound above upper bound forces every phase to duty_max
  task automatic test_inverted_bounds();
    settle();
    write_reg(svpwm_pkg::CFG_DUTY_MIN, 16'd30000);
    write_reg(svpwm_pkg::CFG_DUTY_MAX, 16'd100);
    write_reg(svpwm_pkg::CFG_TIMER_MAX, svpwm_pkg::TIMER_MAX_RST);
    send_corners(4);
  endtask

  // bit 15 of the duty registers is dropped, index 3 is ignored
  task automatic test_register_masking();
    settle();
    write_reg(svpwm_pkg::CFG_DUTY_MIN, 16'h8000);
    write_reg(svpwm_pkg::CFG_DUTY_MAX, 16'hffff);
    write_reg(svpwm_pkg::CFG_TIMER_MAX, 16'd0);
    write_reg(CFG_UNUSED, 16'h1234);
    send_corners(2);
    settle();
    write_reg(svpwm_pkg::CFG_TIMER_MAX, 16'd1);
    write_reg(CFG_UNUSED, 16'hffff);
    send_corners(2);
  endtask

  // receiver holds off while the sender keeps offering, so s_tready drops
  task automatic test_output_backpressure();
    settle();
    write_reg(svpwm_pkg::CFG_DUTY_MIN, 16'(svpwm_pkg::DUTY_MIN_RST));
    write_reg(svpwm_pkg::CFG_DUTY_MAX, 16'(svpwm_pkg::DUTY_MAX_RST));
    write_reg(svpwm_pkg::CFG_TIMER_MAX, svpwm_pkg::TIMER_MAX_RST);
    tx_steady = 1'b1;
    stall_request = 200;
    for (int i = 0; i < 40; i++) send_vector($urandom);
    tx_steady = 1'b0;
  endtask

  task automatic test_random_vectors();
    logic [15:0] dmin, dmax, tmax;
    logic [31:0] vec;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case ($urandom_range(0, 5))
        0: begin
          dmin = 16'(svpwm_pkg::DUTY_MIN_RST);
          dmax = 16'(svpwm_pkg::DUTY_MAX_RST);
          tmax = svpwm_pkg::TIMER_MAX_RST;
        end
        1: begin
          dmin = 16'($urandom_range(0, 16000));
          dmax = 16'($urandom_range(16000, 32767));
          tmax = 16'($urandom_range(0, 65535));
        end
        2: begin
          dmin = 16'($urandom_range(16001, 32767));
          dmax = 16'($urandom_range(0, 16000));
          tmax = 16'($urandom_range(0, 65535));
        end
        3: begin dmin = 16'd0; dmax = 16'd0; tmax = 16'd0; end
        4: begin
          dmin = 16'(svpwm_pkg::DUTY_FULL);
          dmax = 16'(svpwm_pkg::DUTY_FULL);
          tmax = svpwm_pkg::TIMER_MAX_RST;
        end
        default: begin
          dmin = 16'($urandom);
          dmax = 16'($urandom);
          tmax = 16'($urandom);
        end
      endcase
      write_reg(svpwm_pkg::CFG_DUTY_MIN, dmin);
      write_reg(svpwm_pkg::CFG_DUTY_MAX, dmax);
      write_reg(svpwm_pkg::CFG_TIMER_MAX, tmax);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 210; i++) begin
        case ($urandom_range(0, 9))
          6, 7: begin
            vec[15:0] = 16'($urandom_range(0, 2047) - 1024);
            vec[31:16] = 16'($urandom_range(0, 2047) - 1024);
          end
          8: begin
            vec[15:0] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            vec[31:16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
          end
          9: vec = corner_vector($urandom_range(0, 11));
          default: vec = $urandom;
        endcase
        send_vector(vec);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_narrow_window();
    test_inverted_bounds();
    test_register_masking();
    test_output_backpressure();
    test_random_vectors();
    settle();
    repeat (10) @(posedge clk);
    if (bad_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
